[hw/rtl/fsts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fsts_pkg;

	// Fixed field and register widths.
	localparam int OP_W      = 3;
	localparam int SPEED_W   = 3;
	localparam int FRAME_W   = 32;
	localparam int PERIOD_W  = 44;
	localparam int CAP_REG_W = 8;

	// Configuration port geometry: registers sit on 8-byte boundaries.
	localparam int APB_DATA_W   = 64;
	localparam int APB_ADDR_W   = 5;
	localparam int REG_ADDR_LSB = 3;
	localparam int REG_IDX_W    = APB_ADDR_W - REG_ADDR_LSB;

	localparam logic [REG_IDX_W-1:0] REG_DAY_PERIOD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_FRAME  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_STEPS  = 2'd2;

	localparam logic [PERIOD_W-1:0]  DAY_PERIOD_RST = 44'd1000000;
	localparam logic [FRAME_W-1:0]   MAX_FRAME_RST  = 32'd250000;
	localparam logic [CAP_REG_W-1:0] MAX_STEPS_RST  = 8'd8;

	// Operation codes; code 7 is unused and does nothing.
	localparam logic [OP_W-1:0] OP_ADVANCE   = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_SPEED = 3'd1;
	localparam logic [OP_W-1:0] OP_SUSPEND   = 3'd2;
	localparam logic [OP_W-1:0] OP_RESUME    = 3'd3;
	localparam logic [OP_W-1:0] OP_HOLD      = 3'd4;
	localparam logic [OP_W-1:0] OP_RELEASE   = 3'd5;
	localparam logic [OP_W-1:0] OP_RESET     = 3'd6;

	// Speed codes; anything above x8 is taken as paused.
	localparam logic [SPEED_W-1:0] SPEED_PAUSED = 3'd0;
	localparam logic [SPEED_W-1:0] SPEED_X1     = 3'd1;
	localparam logic [SPEED_W-1:0] SPEED_X2     = 3'd2;
	localparam logic [SPEED_W-1:0] SPEED_X4     = 3'd3;
	localparam logic [SPEED_W-1:0] SPEED_X8     = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD,
		ST_PAY,
		ST_SETTLE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  day_period_us;
		logic [FRAME_W-1:0]   max_frame_us;
		logic [CAP_REG_W-1:0] step_cap;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic add;
		logic pay;
		logic settle;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic adv_run;
		logic pay_done;
	} dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/fsts_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fsts_item_if;
	logic                              valid;
	logic                              ready;
	logic [fsts_pkg::OP_W-1:0]         operation;
	logic [fsts_pkg::SPEED_W-1:0]      speed_code;
	logic [fsts_pkg::FRAME_W-1:0]      frame_delta;

	modport source(output valid, operation, speed_code, frame_delta, input ready);
	modport sink(input valid, operation, speed_code, frame_delta, output ready);
endinterface

interface fsts_result_if #(
	parameter int ACC_WIDTH  = 44,
	parameter int STEP_WIDTH = 8
);
	logic                  valid;
	logic                  ready;
	logic [STEP_WIDTH-1:0] steps;
	logic [ACC_WIDTH-1:0]  accumulated_us;

	modport source(output valid, steps, accumulated_us, input ready);
	modport sink(input valid, steps, accumulated_us, output ready);
endinterface

`default_nettype wire

[hw/rtl/fsts_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsts_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [fsts_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [fsts_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [fsts_pkg::APB_DATA_W-1:0]     prdata,
	output fsts_pkg::cfg_t                           cfg
);

	logic [fsts_pkg::REG_IDX_W-1:0] idx;
	logic                           wr_en;
	fsts_pkg::cfg_t                 cfg_q;

	assign idx   = paddr[fsts_pkg::APB_ADDR_W-1:fsts_pkg::REG_ADDR_LSB];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.day_period_us <= fsts_pkg::DAY_PERIOD_RST;
			cfg_q.max_frame_us  <= fsts_pkg::MAX_FRAME_RST;
			cfg_q.step_cap      <= fsts_pkg::MAX_STEPS_RST;
		end else if (wr_en) begin
			unique case (idx)
				fsts_pkg::REG_DAY_PERIOD: begin
					cfg_q.day_period_us <= pwdata[fsts_pkg::PERIOD_W-1:0];
				end
				fsts_pkg::REG_MAX_FRAME: begin
					cfg_q.max_frame_us <= pwdata[fsts_pkg::FRAME_W-1:0];
				end
				fsts_pkg::REG_MAX_STEPS: begin
					cfg_q.step_cap <= pwdata[fsts_pkg::CAP_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fsts_pkg::REG_DAY_PERIOD: prdata = fsts_pkg::APB_DATA_W'(cfg_q.day_period_us);
			fsts_pkg::REG_MAX_FRAME:  prdata = fsts_pkg::APB_DATA_W'(cfg_q.max_frame_us);
			fsts_pkg::REG_MAX_STEPS:  prdata = fsts_pkg::APB_DATA_W'(cfg_q.step_cap);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/fsts_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsts_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire fsts_pkg::dp_status_t status,
	output fsts_pkg::dp_cmd_t         cmd
);

	fsts_pkg::ctrl_state_t state_q;
	fsts_pkg::ctrl_state_t state_n;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			fsts_pkg::ST_IDLE: begin
				if (in_valid) state_n = fsts_pkg::ST_DECODE;
			end
			fsts_pkg::ST_DECODE: begin
				state_n = status.adv_run ? fsts_pkg::ST_ADD : fsts_pkg::ST_EMIT;
			end
			fsts_pkg::ST_ADD: begin
				state_n = fsts_pkg::ST_PAY;
			end
			fsts_pkg::ST_PAY: begin
				if (status.pay_done) state_n = fsts_pkg::ST_SETTLE;
			end
			fsts_pkg::ST_SETTLE: begin
				state_n = fsts_pkg::ST_EMIT;
			end
			fsts_pkg::ST_EMIT: begin
				if (slot_free) state_n = fsts_pkg::ST_IDLE;
			end
			default: begin
				state_n = fsts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fsts_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			fsts_pkg::ST_DECODE: cmd.decode = 1'b1;
			fsts_pkg::ST_ADD:    cmd.add    = 1'b1;
			fsts_pkg::ST_PAY:    cmd.pay    = 1'b1;
			fsts_pkg::ST_SETTLE: cmd.settle = 1'b1;
			fsts_pkg::ST_EMIT:   cmd.emit   = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// A pending result is never overwritten.
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result emitted over a pending beat");

	// The datapath gets at most one command per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.decode, cmd.add, cmd.pay, cmd.settle, cmd.emit}))
		else $error("more than one datapath command");

	// The accumulate path is entered only for an advance that runs.
	a_add_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fsts_pkg::ST_ADD |-> $past(status.adv_run))
		else $error("accumulate entered without a running advance");
`endif

endmodule

`default_nettype wire

[hw/rtl/fsts_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsts_datapath #(
	parameter int ACC_WIDTH  = 44,
	parameter int STEP_WIDTH = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fsts_pkg::cfg_t                    cfg,
	input  wire fsts_pkg::dp_cmd_t                 cmd,
	input  wire logic [fsts_pkg::OP_W-1:0]         operation,
	input  wire logic [fsts_pkg::SPEED_W-1:0]      speed_code,
	input  wire logic [fsts_pkg::FRAME_W-1:0]      frame_delta,
	output fsts_pkg::dp_status_t                   status,
	output logic      [STEP_WIDTH-1:0]             steps,
	output logic      [ACC_WIDTH-1:0]              accumulated_us
);

	localparam int CMP_W = (ACC_WIDTH > fsts_pkg::PERIOD_W) ? ACC_WIDTH : fsts_pkg::PERIOD_W;
	localparam int ADD_W = ((ACC_WIDTH > fsts_pkg::FRAME_W) ? ACC_WIDTH : fsts_pkg::FRAME_W) + 1;
	localparam int CAP_W = (STEP_WIDTH > fsts_pkg::CAP_REG_W) ? STEP_WIDTH : fsts_pkg::CAP_REG_W;
	localparam logic [ACC_WIDTH-1:0]  ACC_MAX  = '1;
	localparam logic [STEP_WIDTH-1:0] STEP_MAX = '1;

	// Item registers
	logic [fsts_pkg::OP_W-1:0]     op_q;
	logic [fsts_pkg::SPEED_W-1:0]  code_q;
	logic [fsts_pkg::FRAME_W-1:0]  delta_q;

	// Scheduler state
	logic [ACC_WIDTH-1:0]          acc_q;
	logic [fsts_pkg::SPEED_W-1:0]  speed_q;
	logic                          suspended_q;
	logic                          held_q;

	// Working registers of one advance
	logic [fsts_pkg::PERIOD_W-1:0] period_q;
	logic [fsts_pkg::FRAME_W-1:0]  frame_q;
	logic [ACC_WIDTH-1:0]          sum_q;
	logic [STEP_WIDTH-1:0]         cap_q;
	logic [STEP_WIDTH-1:0]         count_q;
	logic [STEP_WIDTH-1:0]         out_steps_q;
	logic [ACC_WIDTH-1:0]          out_acc_q;

	logic [fsts_pkg::PERIOD_W-1:0] period_shift;
	logic                          speed_on;
	logic [fsts_pkg::PERIOD_W-1:0] period_c;
	logic [fsts_pkg::FRAME_W-1:0]  frame_c;
	logic [CAP_W-1:0]              cap_ext;
	logic [STEP_WIDTH-1:0]         cap_c;
	logic [ADD_W-1:0]              add_c;
	logic [ACC_WIDTH-1:0]          sum_c;
	logic [CMP_W-1:0]              sum_ext;
	logic [CMP_W-1:0]              period_ext;
	logic                          pay_go;
	logic [ACC_WIDTH-1:0]          diff_c;
	logic [ACC_WIDTH-1:0]          settle_c;
	logic [fsts_pkg::SPEED_W-1:0]  code_n;

	always_comb begin
		speed_on = cfg.day_period_us != '0;
		unique case (speed_q)
			fsts_pkg::SPEED_X1: period_shift = cfg.day_period_us;
			fsts_pkg::SPEED_X2: period_shift = cfg.day_period_us >> 1;
			fsts_pkg::SPEED_X4: period_shift = cfg.day_period_us >> 2;
			fsts_pkg::SPEED_X8: period_shift = cfg.day_period_us >> 3;
			default: begin
				period_shift = '0;
				speed_on     = 1'b0;
			end
		endcase
	end

	// A running period never drops below one microsecond.
	assign period_c = (speed_on && period_shift == '0) ? fsts_pkg::PERIOD_W'(1) : period_shift;
	assign frame_c  = (delta_q < cfg.max_frame_us) ? delta_q : cfg.max_frame_us;

	// A cap of zero acts as one and saturates at the widest step count.
	assign cap_ext = CAP_W'(cfg.step_cap);
	always_comb begin
		if (cfg.step_cap == '0) begin
			cap_c = STEP_WIDTH'(1);
		end else if (cap_ext > CAP_W'(STEP_MAX)) begin
			cap_c = STEP_MAX;
		end else begin
			cap_c = STEP_WIDTH'(cap_ext);
		end
	end

	assign status.adv_run = (op_q == fsts_pkg::OP_ADVANCE) && !suspended_q && !held_q
		&& (period_c != '0) && (frame_c != '0);

	assign add_c = ADD_W'(acc_q) + ADD_W'(frame_q);
	assign sum_c = (add_c > ADD_W'(ACC_MAX)) ? ACC_MAX : ACC_WIDTH'(add_c);

	assign sum_ext         = CMP_W'(sum_q);
	assign period_ext      = CMP_W'(period_q);
	assign pay_go          = (count_q < cap_q) && (sum_ext >= period_ext);
	assign status.pay_done = !pay_go;
	assign diff_c          = ACC_WIDTH'(sum_ext - period_ext);
	assign settle_c        = (sum_ext > period_ext) ? ACC_WIDTH'(period_ext) : sum_q;

	assign code_n = (code_q > fsts_pkg::SPEED_X8) ? fsts_pkg::SPEED_PAUSED : code_q;

	assign steps          = out_steps_q;
	assign accumulated_us = out_acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			speed_q     <= fsts_pkg::SPEED_PAUSED;
			suspended_q <= 1'b0;
			held_q      <= 1'b0;
			cap_q       <= STEP_WIDTH'(1);
			count_q     <= '0;
		end else begin
			if (cmd.decode) begin
				cap_q   <= cap_c;
				count_q <= '0;
				unique case (op_q)
					fsts_pkg::OP_SET_SPEED: begin
						if (code_n != speed_q) begin
							speed_q <= code_n;
							if (code_n == fsts_pkg::SPEED_PAUSED) acc_q <= '0;
						end
					end
					fsts_pkg::OP_SUSPEND: begin
						suspended_q <= 1'b1;
						acc_q       <= '0;
					end
					fsts_pkg::OP_RESUME: begin
						suspended_q <= 1'b0;
					end
					fsts_pkg::OP_HOLD: begin
						held_q <= 1'b1;
						acc_q  <= '0;
					end
					fsts_pkg::OP_RELEASE: begin
						held_q <= 1'b0;
					end
					fsts_pkg::OP_RESET: begin
						acc_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.pay && pay_go) begin
				count_q <= count_q + STEP_WIDTH'(1);
			end
			if (cmd.settle) begin
				acc_q <= settle_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			code_q  <= speed_code;
			delta_q <= frame_delta;
		end
		if (cmd.decode) begin
			period_q <= period_c;
			frame_q  <= frame_c;
		end
		if (cmd.add) begin
			sum_q <= sum_c;
		end else if (cmd.pay && pay_go) begin
			sum_q <= diff_c;
		end
		if (cmd.emit) begin
			out_steps_q <= count_q;
			out_acc_q   <= acc_q;
		end
	end

`ifndef SYNTH
	// The payout loop stops at the step cap.
	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("step count above cap");

	// After an advance the carried remainder is at most one period.
	a_settle_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.settle |=> CMP_W'(acc_q) <= period_ext)
		else $error("remainder exceeds one period");

	// Undefined speed codes are folded to paused before they are stored.
	a_speed_legal: assert property (@(posedge clk) disable iff (!arst_n)
		speed_q <= fsts_pkg::SPEED_X8)
		else $error("speed register holds an undefined code");
`endif

endmodule

`default_nettype wire

[hw/rtl/fixed_step_tick_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Fixed-step tick scheduler. Each item beat on the item channel carries an
// operation: advance by frame_delta microseconds, set the speed (paused, x1,
// x2, x4, x8), suspend, resume, hold, release the hold, or clear the
// accumulator. Each item yields exactly one result beat with the number of
// whole simulation steps due (zero for anything but an advance) and the
// accumulator value after the item. An advance clamps its delta to
// max_frame_us, adds it to the accumulator with saturation, pays out whole
// step periods up to the step cap, and keeps at most one period as
// remainder. The step period is day_period_us shifted down by the speed,
// never less than one; a zero period, paused speed, suspension or hold makes
// an advance pay nothing. The block takes one item at a time. A
// non-advance item, or an advance that does not run, goes from decode to
// emit; an advance also passes accumulate, payout and settle, and the payout
// loop runs one subtraction of the period per cycle through a single
// subtractor. A finished result sits in an output register, so the next item
// is accepted while that beat still waits; the block stalls only if a second
// result is ready before the first is taken. Configuration is written over
// the APB port at byte addresses 0x00 (day_period_us), 0x08 (max_frame_us)
// and 0x10 (step_cap), 64-bit data. The user must write it only while the
// block is idle; the block itself does not enforce this.

module fixed_step_tick_scheduler #(
	parameter int ACC_WIDTH  = 44,
	parameter int STEP_WIDTH = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	fsts_item_if.sink                            item,
	fsts_result_if.source                        result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [fsts_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [fsts_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [fsts_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	fsts_pkg::cfg_t        cfg;
	fsts_pkg::dp_cmd_t     cmd;
	fsts_pkg::dp_status_t  status;
	logic [STEP_WIDTH-1:0] steps;
	logic [ACC_WIDTH-1:0]  accumulated_us;

	// Register writes complete in the access phase without wait states.
	assign pready = 1'b1;

	fsts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The controller sequences decode, accumulate, payout, settle and emit.
	fsts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the scheduler state and the shared payout subtractor.
	fsts_datapath #(
		.ACC_WIDTH  (ACC_WIDTH),
		.STEP_WIDTH (STEP_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.operation      (item.operation),
		.speed_code     (item.speed_code),
		.frame_delta    (item.frame_delta),
		.status         (status),
		.steps          (steps),
		.accumulated_us (accumulated_us)
	);

	assign result.steps          = steps;
	assign result.accumulated_us = accumulated_us;

endmodule

`default_nettype wire

[bench/tick_checker.sv]
`timescale 1ns / 1ps

// Watches the item, result and register channels of the tick scheduler. It keeps
// its own copy of the scheduler state and registers and works out the result
// of every accepted item. It then compares each result beat with the oldest
// outstanding one.
module tick_checker #(
	parameter int ACC_WIDTH  = 44,
	parameter int STEP_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fsts_item_if                             item,
	fsts_result_if                           result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [fsts_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [fsts_pkg::APB_DATA_W-1:0]  pwdata,
	output int unsigned                      outstanding,
	output int unsigned                      mismatches,
	output int unsigned                      compared,
	output longint unsigned                  steps_paid
);
	import fsts_pkg::*;

	localparam logic [63:0] ACC_MAX  = (64'd1 << ACC_WIDTH) - 64'd1;
	localparam logic [63:0] STEP_MAX = (64'd1 << STEP_WIDTH) - 64'd1;

	typedef struct packed {
		logic [STEP_WIDTH-1:0] steps;
		logic [ACC_WIDTH-1:0]  accumulated_us;
	} tick_t;

	logic [63:0]        acc_us;
	logic [SPEED_W-1:0] speed;
	logic               suspended;
	logic               held;
	cfg_t               regs;
	tick_t              due_q[$];

	// Zero means the scheduler cannot step at all.
	function automatic logic [63:0] step_period();
		logic [63:0] p;
		if (speed < SPEED_X1 || speed > SPEED_X8 || regs.day_period_us == '0)
			return '0;
		p = 64'(regs.day_period_us) >> (speed - SPEED_X1);
		return (p == '0) ? 64'd1 : p;
	endfunction

	function automatic tick_t apply_item(input logic [OP_W-1:0] op,
		input logic [SPEED_W-1:0] code, input logic [FRAME_W-1:0] delta);
		tick_t r;
		logic [63:0] period, clamped, total, cap, paid;
		logic [SPEED_W-1:0] next_speed;
		r.steps = '0;
		case (op)
			OP_ADVANCE: begin
				period  = step_period();
				clamped = (64'(delta) < 64'(regs.max_frame_us)) ? 64'(delta)
					: 64'(regs.max_frame_us);
				if (!suspended && !held && period != '0 && clamped != '0) begin
					total = acc_us + clamped;
					if (total > ACC_MAX)
						total = ACC_MAX;
					cap = (regs.step_cap == '0) ? 64'd1 : 64'(regs.step_cap);
					if (cap > STEP_MAX)
						cap = STEP_MAX;
					paid = total / period;
					if (paid > cap)
						paid = cap;
					total = total - paid * period;
					if (total > period)
						total = period;
					acc_us  = total;
					r.steps = paid[STEP_WIDTH-1:0];
				end
			end
			OP_SET_SPEED: begin
				next_speed = (code > SPEED_X8) ? SPEED_PAUSED : code;
				if (next_speed != speed) begin
					speed = next_speed;
					if (next_speed == SPEED_PAUSED)
						acc_us = '0;
				end
			end
			OP_SUSPEND: begin
				suspended = 1'b1;
				acc_us    = '0;
			end
			OP_RESUME:  suspended = 1'b0;
			OP_HOLD: begin
				held   = 1'b1;
				acc_us = '0;
			end
			OP_RELEASE: held = 1'b0;
			OP_RESET:   acc_us = '0;
			default: ;
		endcase
		r.accumulated_us = acc_us[ACC_WIDTH-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_t want;
		if (!arst_n) begin
			acc_us    = '0;
			speed     = SPEED_PAUSED;
			suspended = 1'b0;
			held      = 1'b0;
			regs.day_period_us = DAY_PERIOD_RST;
			regs.max_frame_us  = MAX_FRAME_RST;
			regs.step_cap      = MAX_STEPS_RST;
			due_q.delete();
			mismatches  = 0;
			compared    = 0;
			steps_paid  = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:REG_ADDR_LSB])
					REG_DAY_PERIOD: regs.day_period_us = pwdata[PERIOD_W-1:0];
					REG_MAX_FRAME:  regs.max_frame_us  = pwdata[FRAME_W-1:0];
					REG_MAX_STEPS:  regs.step_cap      = pwdata[CAP_REG_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				want = apply_item(item.operation, item.speed_code, item.frame_delta);
				steps_paid += want.steps;
				due_q.insert(due_q.size(), want);
			end
			if (result.valid && result.ready) begin
				compared++;
				if (due_q.size() == 0) begin
					$error("result beat with no item pending: steps %0d, accumulated_us %0d",
						result.steps, result.accumulated_us);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					if (result.steps !== want.steps) begin
						$error("steps: expected %0d, actual %0d", want.steps, result.steps);
						mismatches++;
					end
					if (result.accumulated_us !== want.accumulated_us) begin
						$error("accumulated_us: expected %0d, actual %0d",
							want.accumulated_us, result.accumulated_us);
						mismatches++;
					end
				end
			end
			outstanding <= due_q.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Top of the tick scheduler bench. This module only makes stimulus and
// announces the verdict; all prediction and comparison lives in tick_checker.
module tb;
	import fsts_pkg::*;

	localparam int ACC_WIDTH  = 44;
	localparam int STEP_WIDTH = 8;

	// Codes outside the defined sets, used to hit the fall-through behavior.
	localparam logic [OP_W-1:0]    OP_UNUSED    = 3'd7;
	localparam logic [SPEED_W-1:0] SPEED_BAD_LO = 3'd5;
	localparam logic [SPEED_W-1:0] SPEED_BAD_HI = 3'd7;

	localparam logic [63:0] PERIOD_MAX  = (64'd1 << PERIOD_W) - 64'd1;
	localparam int unsigned PHASE_ITEMS = 125;

	// With the period at its largest every maximum frame only adds to the
	// carried remainder, so this burst exercises the widest sums.
	localparam int unsigned LARGE_PERIOD_BEATS = 24;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	int unsigned     outstanding;
	int unsigned     mismatches;
	int unsigned     compared;
	longint unsigned steps_paid;

	// Stimulus bookkeeping. cur_period and cur_frame only steer the random
	// deltas toward interesting sizes; they play no part in checking.
	logic [63:0]        cur_period;
	logic [FRAME_W-1:0] cur_frame;
	int unsigned        items_sent;
	int unsigned        advances_sent;
	int unsigned        settings_used;
	bit                 src_gaps;
	logic               sink_stalls;
	int unsigned        ready_hold;

	fsts_item_if item_ch();
	fsts_result_if #(.ACC_WIDTH(ACC_WIDTH), .STEP_WIDTH(STEP_WIDTH)) result_ch();

	fixed_step_tick_scheduler #(
		.ACC_WIDTH (ACC_WIDTH),
		.STEP_WIDTH(STEP_WIDTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	tick_checker #(
		.ACC_WIDTH (ACC_WIDTH),
		.STEP_WIDTH(STEP_WIDTH)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.outstanding(outstanding),
		.mismatches (mismatches),
		.compared   (compared),
		.steps_paid (steps_paid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle lengths for both sides: mostly a few cycles, now and then a long one.
	function automatic int unsigned gap_len();
		if ($urandom_range(99) < 85)
			return $urandom_range(3);
		return $urandom_range(60, 10);
	endfunction

	// Frame deltas. Most are scaled to the programmed period so that payouts
	// come out as small whole counts; the rest are the edges of the field,
	// single set bits, values right at the clamp, and plain noise.
	function automatic logic [FRAME_W-1:0] rand_delta();
		int unsigned pick;
		logic [63:0] upper;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		if (pick < 16)
			return '1;
		if (pick < 26)
			return FRAME_W'(1) << $urandom_range(FRAME_W - 1);
		if (pick < 34)
			return cur_frame - FRAME_W'(1) + FRAME_W'($urandom_range(2));
		if (pick < 46 || cur_period == '0 || cur_period > 64'hFFFF_FFFF)
			return $urandom;
		upper = cur_period * $urandom_range(1, 3);
		if (upper > 64'hFFFF_FFFF)
			upper = 64'hFFFF_FFFF;
		return $urandom_range(upper[31:0]);
	endfunction

	// Result side. The receiver drops ready for random stretches while stalls
	// are enabled, and keeps it high otherwise.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			ready_hold      <= 0;
		end else if (ready_hold != 0) begin
			ready_hold      <= ready_hold - 1;
			result_ch.ready <= 1'b0;
		end else if (sink_stalls && $urandom_range(99) < 15) begin
			ready_hold      <= gap_len();
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Presents one item and holds it until the beat is taken. With no gap the
	// valid stays high so the next call can present its item on the very next
	// cycle.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SPEED_W-1:0] code,
		input logic [FRAME_W-1:0] delta);
		int unsigned gap;
		item_ch.valid       <= 1'b1;
		item_ch.operation   <= op;
		item_ch.speed_code  <= code;
		item_ch.frame_delta <= delta;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (op == OP_ADVANCE)
			advances_sent++;
		gap = src_gaps ? gap_len() : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every result beat has been taken. The
	// checker registers its count, so the loop waits on the clock before its
	// first sample. A short pause follows so the block is surely idle.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// One register write: setup cycle, access cycle, then an idle cycle so
	// that back-to-back writes never touch psel twice in one step.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(idx) << REG_ADDR_LSB;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [63:0] period, input logic [FRAME_W-1:0] frame,
		input logic [CAP_REG_W-1:0] cap);
		drain_results();
		write_reg(REG_DAY_PERIOD, period);
		write_reg(REG_MAX_FRAME, 64'(frame));
		write_reg(REG_MAX_STEPS, 64'(cap));
		cur_period = period;
		cur_frame  = frame;
		settings_used++;
	endtask

	// Clears suspension and hold and selects a running speed, so that the
	// random items that follow start from a state where advances can pay out.
	task automatic start_running(input logic [SPEED_W-1:0] speed);
		send_item(OP_RESUME, SPEED_W'($urandom), $urandom);
		send_item(OP_RELEASE, SPEED_W'($urandom), $urandom);
		send_item(OP_SET_SPEED, speed, $urandom);
	endtask

	// Random traffic, heavy on advances. Suspend and hold come up less often
	// than resume and release so the scheduler spends most of its time
	// running. Idling is re-rolled every 40 items, and some of those stretches
	// run with no idling at all. Halfway through, the sender waits for every
	// outstanding result.
	task automatic random_items(input int unsigned count);
		logic [OP_W-1:0]    op;
		logic [SPEED_W-1:0] code;
		logic [FRAME_W-1:0] delta;
		int unsigned        pick;
		bit                 quiet;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				quiet       = ($urandom_range(3) == 0);
				src_gaps    = !quiet;
				sink_stalls <= !quiet;
			end
			if (i == count / 2)
				drain_results();
			pick = $urandom_range(99);
			if (pick < 64)
				op = OP_ADVANCE;
			else if (pick < 76)
				op = OP_SET_SPEED;
			else if (pick < 79)
				op = OP_SUSPEND;
			else if (pick < 85)
				op = OP_RESUME;
			else if (pick < 88)
				op = OP_HOLD;
			else if (pick < 94)
				op = OP_RELEASE;
			else if (pick < 98)
				op = OP_RESET;
			else
				op = OP_UNUSED;
			code  = SPEED_W'($urandom);
			delta = $urandom;
			if (op == OP_SET_SPEED) begin
				pick = $urandom_range(99);
				if (pick < 70)
					code = $urandom_range(SPEED_X1, SPEED_X8);
				else if (pick < 85)
					code = SPEED_PAUSED;
				else
					code = $urandom_range(SPEED_BAD_LO, SPEED_BAD_HI);
			end
			if (op == OP_ADVANCE)
				delta = rand_delta();
			send_item(op, code, delta);
		end
	endtask

	initial begin
		logic [63:0]          period;
		logic [FRAME_W-1:0]   frame;
		logic [CAP_REG_W-1:0] cap;

		// Every input is known from time zero while reset is held.
		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.operation   <= OP_ADVANCE;
		item_ch.speed_code  <= SPEED_PAUSED;
		item_ch.frame_delta <= '0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		sink_stalls         <= 1'b0;
		src_gaps      = 1'b0;
		cur_period    = 64'(DAY_PERIOD_RST);
		cur_frame     = MAX_FRAME_RST;
		items_sent    = 0;
		advances_sent = 0;
		settings_used = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset register values: 1 s period, 250 ms
		// clamp, eight steps per frame. Speed starts out paused.
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd1000);     // no period yet
		send_item(OP_UNUSED, SPEED_X2, '1);                // undefined operation
		send_item(OP_SET_SPEED, SPEED_X1, '0);
		send_item(OP_SET_SPEED, SPEED_X1, '0);             // same speed again
		send_item(OP_ADVANCE, SPEED_PAUSED, '0);           // zero delta
		send_item(OP_ADVANCE, SPEED_PAUSED, '1);           // clamped to 250 ms
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd250000);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd250000);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd250000);   // one whole step
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd200000);
		send_item(OP_SUSPEND, SPEED_PAUSED, '0);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd500000);   // suspended
		send_item(OP_RESUME, SPEED_PAUSED, '0);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd100000);
		send_item(OP_HOLD, SPEED_PAUSED, '0);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd300000);   // held
		send_item(OP_RELEASE, SPEED_PAUSED, '0);
		send_item(OP_SET_SPEED, SPEED_X8, '0);
		send_item(OP_ADVANCE, SPEED_PAUSED, '1);           // two steps at x8
		send_item(OP_SET_SPEED, SPEED_X2, '0);
		send_item(OP_SET_SPEED, SPEED_X4, '0);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd123456);
		send_item(OP_RESET, SPEED_PAUSED, '0);
		send_item(OP_ADVANCE, SPEED_PAUSED, 32'd99999);
		send_item(OP_SET_SPEED, SPEED_BAD_LO, '0);         // undefined speed pauses

		// Fixed settings at the edges of the registers: stepping disabled,
		// the smallest period with the widest cap, every frame clamped to
		// zero, and a zero cap that must act as one.
		program_regs('0, MAX_FRAME_RST, MAX_STEPS_RST);
		start_running(SPEED_X1);
		random_items(PHASE_ITEMS);
		program_regs(64'd1, '1, '1);
		start_running(SPEED_X8);
		random_items(PHASE_ITEMS);
		program_regs(64'd1000, '0, 8'd1);
		start_running(SPEED_X2);
		random_items(PHASE_ITEMS);
		program_regs(64'd777, 32'd5000, '0);
		start_running(SPEED_X4);
		random_items(PHASE_ITEMS);

		// Largest period: a back-to-back burst of maximum frames that keeps
		// growing the carried remainder.
		program_regs(PERIOD_MAX, '1, 8'd1);
		send_item(OP_RESET, SPEED_PAUSED, '0);
		start_running(SPEED_X1);
		src_gaps = 1'b0;
		sink_stalls <= 1'b0;
		repeat (LARGE_PERIOD_BEATS) send_item(OP_ADVANCE, SPEED_W'($urandom), '1);
		random_items(PHASE_ITEMS / 2);

		// Random settings, with the extremes of each register among the picks.
		repeat (6) begin
			case ($urandom_range(5))
				0:       period = '0;
				1:       period = $urandom_range(1, 15);
				2:       period = $urandom_range(16, 5000);
				3:       period = 64'(DAY_PERIOD_RST);
				4:       period = 64'($urandom);
				default: period = {$urandom, $urandom} & PERIOD_MAX;
			endcase
			case ($urandom_range(4))
				0:       frame = '0;
				1:       frame = $urandom_range(1, 200);
				2:       frame = MAX_FRAME_RST;
				3:       frame = '1;
				default: frame = $urandom;
			endcase
			case ($urandom_range(4))
				0:       cap = '0;
				1:       cap = 8'd1;
				2:       cap = $urandom_range(2, 16);
				3:       cap = '1;
				default: cap = CAP_REG_W'($urandom);
			endcase
			program_regs(period, frame, cap);
			start_running($urandom_range(SPEED_X1, SPEED_X8));
			random_items(PHASE_ITEMS);
		end

		// All stimulus is in; let the last results come out, then allow a few
		// more cycles in case the block produces anything unexpected.
		drain_results();
		repeat (12) @(posedge clk);

		$display("Covered %0d items (%0d advances) under %0d register settings,",
			items_sent, advances_sent, settings_used);
		$display("including a burst at the largest period; %0d result beats, %0d steps paid.",
			compared, steps_paid);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, where every frame pays the
	// full cap and waits out the longest gaps on both sides.
	initial begin
		#100_000_000;
		$error("run did not complete before the watchdog expired");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
